/* src/dgsp_pkg.sv */
`timescale 1ns / 1ps
// Package: shared constants and types for the dense graph shortest path block.
package dgsp_pkg;

  localparam int NodesDefault = 8;

  localparam int VTX_W    = 3;
  localparam int WEIGHT_W = 16;
  localparam int DIST_W   = 24;

  localparam logic [WEIGHT_W-1:0] NO_EDGE_HIGH = '1;
  localparam logic [DIST_W-1:0]   DIST_INF     = '1;
  localparam logic [DIST_W-1:0]   DIST_MAXFIN  = DIST_INF - DIST_W'(1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_RELAX,
    ST_OUT_RD,
    ST_OUT_LOAD,
    ST_OUT_HOLD
  } state_e;

endpackage

/* src/dense_graph_shortest_paths.sv */
`timescale 1ns / 1ps
// Top level: single-source shortest paths over a dense adjacency matrix held in memory.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries two kinds of items. A load
//   transfer (kind 0) writes one edge weight into the NODES x NODES matrix memory;
//   weight 0 or all ones means no edge, and vertices at or above NODES are dropped.
//   A run transfer (kind 1) names the source vertex and starts the search; a source
//   at or above NODES is dropped and yields nothing.
//   The output channel (out_valid_o / out_ready_i) then delivers NODES results, one
//   per vertex in index order, with last_o on the final one. Unreachable vertices
//   report the all-ones distance, predecessor 0 and reachable_o low.
//   A load is written straight into the matrix memory. A run settles one vertex per
//   pass (a scan of the distance memory for the minimum, a pick step, a relax sweep
//   over one matrix row); the distance memory's single read port makes the scan and
//   the sweep serial. A full run settles at most NODES vertices, fewer when the search
//   stops early, and then drains by loading each result into the output register in turn.
//   The input is not ready during a run or while results drain.
//   Reset: the matrix memory is cleared by a pass over all NODES*NODES entries, one
//   entry per cycle, during which no item is accepted.
//   A stalled receiver holds the current result in the output register; the search
//   is finished by then, so nothing is lost and the drain simply waits.
module dense_graph_shortest_paths #(
  parameter int NODES = dgsp_pkg::NodesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          kind_i,
  input  logic [dgsp_pkg::VTX_W-1:0]    from_vertex_i,
  input  logic [dgsp_pkg::VTX_W-1:0]    to_vertex_i,
  input  logic [dgsp_pkg::WEIGHT_W-1:0] edge_weight_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dgsp_pkg::VTX_W-1:0]    vertex_o,
  output logic [dgsp_pkg::DIST_W-1:0]   distance_o,
  output logic [dgsp_pkg::VTX_W-1:0]    predecessor_o,
  output logic                          reachable_o,
  output logic                          last_o
);
  import dgsp_pkg::*;

  localparam int IDX_W  = $clog2(NODES);
  localparam int CNT_W  = $clog2(NODES + 1);
  localparam int ADDR_W = $clog2(NODES * NODES);
  localparam int WDEPTH = NODES * NODES;
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(WDEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(NODES);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(NODES - 1);

  // Memories: matrix weights, and distance / predecessor per vertex.
  logic [WEIGHT_W-1:0] wt_mem   [WDEPTH];
  logic [DIST_W-1:0]   dist_mem [NODES];
  logic [IDX_W-1:0]    pred_mem [NODES];

  logic                wm_we, wm_re;
  logic [ADDR_W-1:0]   wm_waddr, wm_raddr;
  logic [WEIGHT_W-1:0] wm_wdata, wm_rdata_q;

  logic                dm_we, dm_re;
  logic [IDX_W-1:0]    dm_waddr, dm_raddr;
  logic [DIST_W-1:0]   dm_wdist, dm_rdist_q;
  logic [IDX_W-1:0]    dm_wpred, dm_rpred_q;

  // Control state.
  state_e              state_q, state_d;
  logic [ADDR_W-1:0]   clr_q, clr_d;
  logic [CNT_W-1:0]    k_q, k_d;
  logic [CNT_W-1:0]    settled_q, settled_d;
  logic [NODES-1:0]    touched_q, touched_d;
  logic [NODES-1:0]    visited_q, visited_d;
  logic                found_q, found_d;
  logic [DIST_W-1:0]   best_d_q, best_d_d;
  logic [IDX_W-1:0]    best_idx_q, best_idx_d;
  logic [IDX_W-1:0]    u_q, u_d;
  logic [DIST_W-1:0]   du_q, du_d;
  logic                out_valid_q, out_valid_d;

  // Output payload register.
  logic [VTX_W-1:0]    vertex_q, vertex_d;
  logic [DIST_W-1:0]   distance_q, distance_d;
  logic [VTX_W-1:0]    pred_q, pred_d;
  logic                reach_q, reach_d;
  logic                last_q, last_d;

  // Input decode.
  logic                in_xfer;
  logic                from_ok, to_ok;
  logic [IDX_W-1:0]    from_idx, to_idx;

  // Datapath helpers.
  logic [IDX_W-1:0]    k_idx, km1_idx;
  logic [DIST_W-1:0]   d_eff;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   cand;
  logic                edge_ok;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign from_ok    = int'(from_vertex_i) < NODES;
  assign to_ok      = int'(to_vertex_i) < NODES;
  assign from_idx   = IDX_W'(from_vertex_i);
  assign to_idx     = IDX_W'(to_vertex_i);

  assign k_idx   = k_q[IDX_W-1:0];
  assign km1_idx = IDX_W'(k_q - CNT_W'(1));

  // The entry read last cycle belongs to vertex k-1; untouched entries read as unreachable.
  assign d_eff   = touched_q[km1_idx] ? dm_rdist_q : DIST_INF;
  assign edge_ok = (wm_rdata_q != '0) && (wm_rdata_q != NO_EDGE_HIGH);
  assign sum     = {1'b0, du_q} + (DIST_W + 1)'(wm_rdata_q);
  assign cand    = (sum > {1'b0, DIST_MAXFIN}) ? DIST_MAXFIN : sum[DIST_W-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    k_d         = k_q;
    settled_d   = settled_q;
    touched_d   = touched_q;
    visited_d   = visited_q;
    found_d     = found_q;
    best_d_d    = best_d_q;
    best_idx_d  = best_idx_q;
    u_d         = u_q;
    du_d        = du_q;
    out_valid_d = out_valid_q;
    vertex_d    = vertex_q;
    distance_d  = distance_q;
    pred_d      = pred_q;
    reach_d     = reach_q;
    last_d      = last_q;

    wm_we    = 1'b0;
    wm_waddr = clr_q;
    wm_wdata = '0;
    wm_re    = 1'b0;
    wm_raddr = ADDR_W'(u_q) * ADDR_W'(NODES) + ADDR_W'(k_idx);
    dm_we    = 1'b0;
    dm_waddr = km1_idx;
    dm_wdist = cand;
    dm_wpred = u_q;
    dm_re    = 1'b0;
    dm_raddr = k_idx;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the matrix to all zero, one entry per cycle.
        wm_we = 1'b1;
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (kind_i == KIND_LOAD) begin
            if (from_ok && to_ok) begin
              wm_we    = 1'b1;
              wm_waddr = ADDR_W'(from_idx) * ADDR_W'(NODES) + ADDR_W'(to_idx);
              wm_wdata = edge_weight_i;
            end
          end else if (from_ok) begin
            // Seed the source and start the first scan.
            dm_we      = 1'b1;
            dm_waddr   = from_idx;
            dm_wdist   = '0;
            dm_wpred   = from_idx;
            touched_d  = '0;
            touched_d[from_idx] = 1'b1;
            visited_d  = '0;
            settled_d  = '0;
            found_d    = 1'b0;
            best_d_d   = DIST_INF;
            best_idx_d = '0;
            k_d        = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (k_q != CNT_END) begin
          dm_re = 1'b1;
          k_d   = k_q + CNT_W'(1);
        end else begin
          state_d = ST_PICK;
        end
        if (k_q != '0) begin
          if (!visited_q[km1_idx] && (d_eff < best_d_q)) begin
            best_d_d   = d_eff;
            best_idx_d = km1_idx;
            found_d    = 1'b1;
          end
        end
      end
      ST_PICK: begin
        k_d = '0;
        if (found_q) begin
          visited_d[best_idx_q] = 1'b1;
          settled_d = settled_q + CNT_W'(1);
          u_d       = best_idx_q;
          du_d      = best_d_q;
          state_d   = ST_RELAX;
        end else begin
          state_d = ST_OUT_RD;
        end
      end
      ST_RELAX: begin
        if (k_q != CNT_END) begin
          dm_re = 1'b1;
          wm_re = 1'b1;
          k_d   = k_q + CNT_W'(1);
        end else begin
          k_d        = '0;
          found_d    = 1'b0;
          best_d_d   = DIST_INF;
          best_idx_d = '0;
          state_d    = (settled_q == CNT_END) ? ST_OUT_RD : ST_SCAN;
        end
        if (k_q != '0) begin
          if (edge_ok && (cand < d_eff)) begin
            dm_we = 1'b1;
            touched_d[km1_idx] = 1'b1;
          end
        end
      end
      ST_OUT_RD: begin
        dm_re   = 1'b1;
        state_d = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        out_valid_d = 1'b1;
        vertex_d    = VTX_W'(k_idx);
        reach_d     = touched_q[k_idx];
        distance_d  = touched_q[k_idx] ? dm_rdist_q : DIST_INF;
        pred_d      = touched_q[k_idx] ? VTX_W'(dm_rpred_q) : '0;
        last_d      = (k_idx == IDX_LAST);
        state_d     = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            k_d      = k_q + CNT_W'(1);
            dm_re    = 1'b1;
            dm_raddr = IDX_W'(k_q + CNT_W'(1));
            state_d  = ST_OUT_LOAD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= '0;
      settled_q   <= '0;
      touched_q   <= '0;
      visited_q   <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      settled_q   <= settled_d;
      touched_q   <= touched_d;
      visited_q   <= visited_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_d_q   <= best_d_d;
    best_idx_q <= best_idx_d;
    u_q        <= u_d;
    du_q       <= du_d;
    vertex_q   <= vertex_d;
    distance_q <= distance_d;
    pred_q     <= pred_d;
    reach_q    <= reach_d;
    last_q     <= last_d;
  end

  // Matrix memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wm_we) begin
      wt_mem[wm_waddr] <= wm_wdata;
    end
    if (wm_re) begin
      wm_rdata_q <= wt_mem[wm_raddr];
    end
  end

  // Distance / predecessor memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (dm_we) begin
      dist_mem[dm_waddr] <= dm_wdist;
      pred_mem[dm_waddr] <= dm_wpred;
    end
    if (dm_re) begin
      dm_rdist_q <= dist_mem[dm_raddr];
      dm_rpred_q <= pred_mem[dm_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign vertex_o      = vertex_q;
  assign distance_o    = distance_q;
  assign predecessor_o = pred_q;
  assign reachable_o   = reach_q;
  assign last_o        = last_q;

endmodule

/* sim/dense_graph_shortest_paths_tb.sv */
`timescale 1ns / 1ps
// Testbench: random and directed self-checking run of the dense graph shortest path block.
module dense_graph_shortest_paths_tb;
  import dgsp_pkg::*;

  localparam int NODES        = NodesDefault;
  localparam int RANDOM_ITEMS = 405;
  localparam int QUIET_TAIL   = 60;
  localparam int PAUSE_AT     = 150;
  localparam int LONG_HOLD    = 600;
  localparam int DRAIN_CYCLES = 2 * NODES + 8;

  typedef struct {
    logic [VTX_W-1:0]  vertex;
    logic [DIST_W-1:0] distance;
    logic [VTX_W-1:0]  predecessor;
    logic              reachable;
    logic              last;
  } path_result_t;

  // One row of the directed table; a run row may carry one typed-in result.
  typedef struct {
    logic                kind;
    logic [VTX_W-1:0]    from_vtx;
    logic [VTX_W-1:0]    to_vtx;
    logic [WEIGHT_W-1:0] weight;
    logic                typed;
    logic [VTX_W-1:0]    t_vtx;
    logic [DIST_W-1:0]   t_dist;
    logic [VTX_W-1:0]    t_pred;
    logic                t_reach;
  } stim_row_t;

  logic clk;
  logic rst_ni = 1'b0;

  logic                in_valid    = 1'b0;
  logic                kind        = KIND_LOAD;
  logic [VTX_W-1:0]    from_vertex = '0;
  logic [VTX_W-1:0]    to_vertex   = '0;
  logic [WEIGHT_W-1:0] edge_weight = '0;
  logic                out_ready   = 1'b1;

  // Typed-in expectation, driven alongside the payload of a run transfer.
  logic                chk_typed = 1'b0;
  logic [VTX_W-1:0]    chk_vtx   = '0;
  logic [DIST_W-1:0]   chk_dist  = '0;
  logic [VTX_W-1:0]    chk_pred  = '0;
  logic                chk_reach = 1'b0;

  logic                in_ready_o;
  logic                out_valid_o;
  logic [VTX_W-1:0]    vertex_o;
  logic [DIST_W-1:0]   distance_o;
  logic [VTX_W-1:0]    predecessor_o;
  logic                reachable_o;
  logic                last_o;

  // Predictor state: the adjacency matrix as the block should hold it.
  logic [WEIGHT_W-1:0] edge_cost [NODES*NODES] = '{default: '0};
  path_result_t        run_out [NODES];
  path_result_t        pending_paths [$];
  stim_row_t           directed_rows [$];

  int  mismatch_count = 0;
  int  runs_accepted  = 0;
  bit  quiet          = 1'b0;
  bit  long_hold_done = 1'b0;

  dense_graph_shortest_paths #(
    .NODES(NODES)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind),
    .from_vertex_i(from_vertex),
    .to_vertex_i  (to_vertex),
    .edge_weight_i(edge_weight),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .vertex_o     (vertex_o),
    .distance_o   (distance_o),
    .predecessor_o(predecessor_o),
    .reachable_o  (reachable_o),
    .last_o       (last_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("dense_graph_shortest_paths verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Settle vertices in order of least distance (lowest index on ties) and fill
  // run_out with one result per vertex. Stop once nothing reachable is left.
  function automatic void solve_paths(input logic [VTX_W-1:0] src);
    logic [DIST_W-1:0]   dist_v [NODES];
    logic [VTX_W-1:0]    pred [NODES];
    bit                  seen [NODES];
    int                  best;
    logic [DIST_W-1:0]   best_d;
    logic [WEIGHT_W-1:0] w;
    logic [DIST_W:0]     cand;
    bit                  reach;
    for (int v = 0; v < NODES; v++) begin
      dist_v[v] = DIST_INF;
      pred[v] = '0;
      seen[v] = 1'b0;
    end
    dist_v[src] = '0;
    pred[src] = src;
    for (int n = 0; n < NODES; n++) begin
      best   = NODES;
      best_d = DIST_INF;
      for (int v = 0; v < NODES; v++) begin
        if (!seen[v] && dist_v[v] < best_d) begin
          best_d = dist_v[v];
          best   = v;
        end
      end
      if (best == NODES) break;
      for (int v = 0; v < NODES; v++) begin
        w = edge_cost[best*NODES + v];
        if (w != '0 && w != NO_EDGE_HIGH) begin
          cand = {1'b0, dist_v[best]} + (DIST_W+1)'(w);
          // Saturate below the unreachable code.
          if (cand > {1'b0, DIST_MAXFIN}) cand = {1'b0, DIST_MAXFIN};
          if (cand[DIST_W-1:0] < dist_v[v]) begin
            dist_v[v] = cand[DIST_W-1:0];
            pred[v] = VTX_W'(best);
          end
        end
      end
      seen[best] = 1'b1;
    end
    for (int v = 0; v < NODES; v++) begin
      reach = (dist_v[v] != DIST_INF);
      run_out[v].vertex      = VTX_W'(v);
      run_out[v].distance    = dist_v[v];
      run_out[v].predecessor = reach ? pred[v] : '0;
      run_out[v].reachable   = reach;
      run_out[v].last        = (v == NODES - 1);
    end
  endfunction

  // Track both channels in one process: input transfers first, then results.
  always @(posedge clk) begin : monitor
    path_result_t want;
    if (rst_ni) begin
      if (in_valid && in_ready_o) begin
        if (kind == KIND_LOAD) begin
          if (int'(from_vertex) < NODES && int'(to_vertex) < NODES)
            edge_cost[from_vertex*NODES + to_vertex] = edge_weight;
        end else if (int'(from_vertex) < NODES) begin
          solve_paths(from_vertex);
          // Replace the predicted entry with the typed-in one where given.
          if (chk_typed) begin
            run_out[chk_vtx].distance    = chk_dist;
            run_out[chk_vtx].predecessor = chk_pred;
            run_out[chk_vtx].reachable   = chk_reach;
          end
          for (int v = 0; v < NODES; v++) pending_paths.push_back(run_out[v]);
          runs_accepted++;
        end
      end
      if (out_valid_o && out_ready) begin
        if (pending_paths.size() == 0) begin
          report_mismatch("result with nothing pending, vertex", vertex_o, 0);
        end else begin
          want = pending_paths.pop_front();
          if (vertex_o !== want.vertex)
            report_mismatch("vertex", vertex_o, want.vertex);
          if (distance_o !== want.distance)
            report_mismatch("distance", distance_o, want.distance);
          if (predecessor_o !== want.predecessor)
            report_mismatch("predecessor", predecessor_o, want.predecessor);
          if (reachable_o !== want.reachable)
            report_mismatch("reachable", reachable_o, want.reachable);
          if (last_o !== want.last)
            report_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  // Receiver: stall in short random bursts, and once hold off long enough that
  // the block backs up and refuses new transfers. No stalls in the quiet tail.
  initial begin : receiver
    int gap;
    forever begin
      @(posedge clk);
      if (!long_hold_done && runs_accepted >= 12 && out_valid_o) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic add_row(input logic k, input int f, input int t, input int w,
                         input logic typed = 1'b0, input int tv = 0,
                         input longint td = 0, input int tp = 0, input logic tr = 1'b0);
    stim_row_t row;
    row.kind     = k;
    row.from_vtx = VTX_W'(f);
    row.to_vtx   = VTX_W'(t);
    row.weight   = WEIGHT_W'(w);
    row.typed    = typed;
    row.t_vtx    = VTX_W'(tv);
    row.t_dist   = DIST_W'(td);
    row.t_pred   = VTX_W'(tp);
    row.t_reach  = tr;
    directed_rows.push_back(row);
  endtask

  // Offer one item and hold it until the transfer. A gap lowers valid first;
  // without a gap valid stays high straight into the next item.
  task automatic drive_item(input stim_row_t row);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    kind        <= row.kind;
    from_vertex <= row.from_vtx;
    to_vertex   <= row.to_vtx;
    edge_weight <= row.weight;
    chk_typed   <= row.typed;
    chk_vtx     <= row.t_vtx;
    chk_dist    <= row.t_dist;
    chk_pred    <= row.t_pred;
    chk_reach   <= row.t_reach;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
  endtask

  // Mostly small weights so that paths compete; the no-edge share varies per phase.
  function automatic logic [WEIGHT_W-1:0] pick_weight(input int no_edge_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < no_edge_pct) return ($urandom_range(0, 1) == 1) ? NO_EDGE_HIGH : '0;
    roll = $urandom_range(0, 9);
    if (roll < 6) return WEIGHT_W'($urandom_range(1, 64));
    if (roll < 9) return WEIGHT_W'($urandom_range(1, 4000));
    return WEIGHT_W'($urandom_range(1, 65534));
  endfunction

  initial begin : sender
    stim_row_t row;
    int        no_edge_pct;
    int        roll;

    // Empty graph right after reset: everything but the source is unreachable.
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 7, DIST_INF, 0, 1'b0);
    add_row(KIND_RUN, 7, 0, 0, 1'b1, 7, 0, 7, 1'b1);
    // Both no-edge codes.
    add_row(KIND_LOAD, 0, 1, 65535);
    add_row(KIND_LOAD, 0, 2, 0);
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 1, DIST_INF, 0, 1'b0);
    // Self loop at the source leaves it at distance 0 pointing to itself.
    add_row(KIND_LOAD, 0, 0, 5);
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 0, 0, 0, 1'b1);
    // Largest real weight twice along one path.
    add_row(KIND_LOAD, 0, 1, 65534);
    add_row(KIND_LOAD, 1, 7, 65534);
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 7, 131068, 1, 1'b1);
    add_row(KIND_LOAD, 0, 7, 1);
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 7, 1, 0, 1'b1);
    // Equal distances: the lower index settles first and keeps the predecessor.
    add_row(KIND_LOAD, 0, 3, 2);
    add_row(KIND_LOAD, 0, 4, 2);
    add_row(KIND_LOAD, 3, 5, 1);
    add_row(KIND_LOAD, 4, 5, 1);
    add_row(KIND_RUN, 0, 0, 0, 1'b1, 5, 3, 3, 1'b1);
    add_row(KIND_LOAD, 7, 6, 16'h8000);
    add_row(KIND_RUN, 5, 0, 0);
    add_row(KIND_LOAD, 6, 2, 16'h7fff);
    add_row(KIND_RUN, 1, 0, 0);
    add_row(KIND_LOAD, 0, 7, 0);
    add_row(KIND_RUN, 0, 0, 0);
    add_row(KIND_LOAD, 5, 0, 1);
    add_row(KIND_RUN, 4, 0, 0);

    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) drive_item(directed_rows[i]);

    no_edge_pct = 40;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = (i >= RANDOM_ITEMS - QUIET_TAIL);
      // Drop valid and hold back until every pending result has drained.
      if (i == PAUSE_AT) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_paths.size() != 0) @(posedge clk);
      end
      row.typed   = 1'b0;
      row.t_vtx   = '0;
      row.t_dist  = '0;
      row.t_pred  = '0;
      row.t_reach = 1'b0;
      row.from_vtx = VTX_W'($urandom_range(0, NODES - 1));
      row.to_vtx   = VTX_W'($urandom_range(0, 7));
      roll = $urandom_range(0, 19);
      if (roll < 3) begin
        row.kind   = KIND_RUN;
        row.weight = WEIGHT_W'($urandom_range(0, 65535));
        // Start a new phase of graph density after each search.
        no_edge_pct = $urandom_range(10, 90);
      end else if (roll == 3) begin
        row.kind   = KIND_LOAD;
        row.weight = WEIGHT_W'($urandom_range(0, 65535));
      end else begin
        row.kind   = KIND_LOAD;
        row.weight = pick_weight(no_edge_pct);
      end
      drive_item(row);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_paths.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_paths.size() != 0)
      report_mismatch("results left pending", pending_paths.size(), 0);

    if (mismatch_count == 0) begin
      $display("dense_graph_shortest_paths verification clean");
    end else begin
      $display("dense_graph_shortest_paths verification failed");
    end
    $finish;
  end

endmodule
